[hdl/ffha_pkg.sv]
// Shared types and codes for the first-fit hole allocator.
`timescale 1ns / 1ps
`default_nettype none
package ffha_pkg;
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_NOFIT = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} req_t;

	// Sequencer states, one-hot.
	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_SCAN  = 9'b000000010,
		S_CHECK = 9'b000000100,
		S_NEXT  = 9'b000001000,
		S_DROP  = 9'b000010000,
		S_SHIFT = 9'b000100000,
		S_WRITE = 9'b001000000,
		S_DONE  = 9'b010000000,
		S_WAIT  = 9'b100000000
	} state_t;
endpackage
`default_nettype wire

[hdl/first_fit_hole_allocator_core.sv]
// Top level of the first-fit hole allocator: sequencer and hole table memory.
//
// Usage: requests enter on the s_axis channel, one per transaction. tdata holds
// block_size and block_start, tuser holds req_type (0 allocate, 1 free). Each
// request gives exactly one result transaction on m_axis: status, grant_address,
// used_units and free_holes packed in tdata.
// The hole table is kept in one synchronous single-port memory (base and
// length side by side) and is walked one entry at a time, each entry read in
// S_SCAN and checked in S_CHECK. A request scans up to the first hole that
// fits or lies above the freed block, shifts the holes above it on removal or
// insertion, then does the final write and loads the result.
// One request is processed at a time; the sequencer returns to idle between requests.
// A new request is taken only once the previous result sits in the output
// register, so a result may wait while the next request is already scanning.
// After reset the S_WAIT state writes a single hole covering all memory into entry 0;
// no clearing pass is needed. If the receiver stalls, the result is held in
// the output register and further results wait until it is taken.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_hole_allocator_core #(
	parameter int MEMORY_UNITS = 1024,
	parameter int MAX_HOLES    = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,   // block_size[10:0], block_start[20:11]
	input  wire logic        s_axis_tuser,   // req_type
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata    // status[1:0], grant_address[11:2],
	                                         // used_units[22:12], free_holes[29:23]
);
	localparam int IW = $clog2(MAX_HOLES);
	localparam int CW = $clog2(MAX_HOLES + 1);

	// Hole table memory: {base, length}.
	logic [20:0] mem [MAX_HOLES];
	logic [20:0] rd_q;
	logic [IW-1:0] addr;
	logic we;
	logic [20:0] wd;

	ffha_pkg::state_t state_q;
	logic        req_q;
	logic [10:0] size_q;
	logic [9:0]  start_q;
	logic [CW-1:0] pos_q;      // scan position
	logic [CW-1:0] total_q;
	logic [10:0] used_q;
	logic [10:0] prev_end_q;   // end of hole pos-1
	logic        has_prev_q;
	logic [20:0] prev_q;       // hole pos-1
	logic [20:0] carry_q;      // entry carried during shift
	logic [CW-1:0] j_q;        // shift index
	logic        ins_q;        // shift direction: insert (up) or drop (down)
	logic        merge_both_q;
	logic        out_busy_q;
	logic [31:0] out_q;

	// Result fields.
	ffha_pkg::status_t st_q;
	logic [9:0] grant_q;

	wire [9:0]  rb = rd_q[20:11];
	wire [10:0] rl = rd_q[10:0];
	wire [11:0] free_end = {1'b0, size_q} + {2'b0, start_q};
	wire        in_scan_range = (pos_q < total_q);

	// Memory port.
	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wd;
		rd_q <= mem[addr];
	end

	assign s_axis_tready = (state_q == ffha_pkg::S_IDLE);
	assign m_axis_tvalid = out_busy_q;
	assign m_axis_tdata  = out_q;

	// Address and write control from the sequencer.
	always_comb begin
		addr = pos_q[IW-1:0];
		we   = 1'b0;
		wd   = '0;
		unique case (state_q)
			ffha_pkg::S_WAIT: begin
				addr = '0;
				we   = 1'b1;
				wd   = {10'd0, 11'(MEMORY_UNITS)};
			end
			ffha_pkg::S_NEXT: begin
				addr = j_q[IW-1:0];
			end
			ffha_pkg::S_SHIFT: begin
				if (ins_q) begin
					addr = j_q[IW-1:0];
					we   = 1'b1;
					wd   = carry_q;
				end else begin
					addr = j_q[IW-1:0];
				end
			end
			ffha_pkg::S_DROP: begin
				addr = j_q[IW-1:0] - IW'(1);
				we   = 1'b1;
				wd   = rd_q;
			end
			ffha_pkg::S_WRITE: begin
				addr = j_q[IW-1:0];
				we   = 1'b1;
				wd   = carry_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ffha_pkg::S_WAIT;
			total_q      <= CW'(1);
			used_q       <= '0;
			out_busy_q   <= 1'b0;
			pos_q        <= '0;
			j_q          <= '0;
			merge_both_q <= 1'b0;
		end else begin
			// Output register: load a finished result, clear on a taken transaction.
			if (state_q == ffha_pkg::S_DONE && (!out_busy_q || m_axis_tready))
				out_busy_q <= 1'b1;
			else if (out_busy_q && m_axis_tready)
				out_busy_q <= 1'b0;
			unique case (state_q)
				ffha_pkg::S_WAIT: begin
					// Entry 0 is seeded with the single full hole this cycle.
					state_q <= ffha_pkg::S_IDLE;
				end
				ffha_pkg::S_IDLE: begin
					if (s_axis_tvalid) begin
						size_q     <= s_axis_tdata[10:0];
						start_q    <= s_axis_tdata[20:11];
						req_q      <= s_axis_tuser;
						pos_q      <= '0;
						has_prev_q <= 1'b0;
						grant_q    <= '0;
						state_q    <= ffha_pkg::S_SCAN;
					end
				end
				ffha_pkg::S_SCAN: begin
					// Entry at pos_q is being read.
					state_q <= ffha_pkg::S_CHECK;
				end
				ffha_pkg::S_CHECK: begin
					if (req_q == ffha_pkg::REQ_ALLOC) begin
						if (size_q == '0 || !in_scan_range) begin
							st_q    <= ffha_pkg::ST_NOFIT;
							state_q <= ffha_pkg::S_DONE;
						end else if (rl >= size_q) begin
							grant_q <= rb;
							st_q    <= ffha_pkg::ST_OK;
							used_q  <= used_q + size_q;
							if (rl == size_q) begin
								ins_q   <= 1'b0;
								j_q     <= pos_q + CW'(1);
								total_q <= total_q - CW'(1);
								state_q <= ffha_pkg::S_SHIFT;
							end else begin
								carry_q <= {rb + size_q[9:0], rl - size_q};
								j_q     <= pos_q;
								state_q <= ffha_pkg::S_WRITE;
							end
						end else begin
							pos_q   <= pos_q + CW'(1);
							state_q <= ffha_pkg::S_SCAN;
						end
					end else begin
						if (size_q == '0 || free_end > 12'(MEMORY_UNITS)) begin
							st_q    <= ffha_pkg::ST_NOFIT;
							state_q <= ffha_pkg::S_DONE;
						end else if (in_scan_range && rb <= start_q) begin
							has_prev_q <= 1'b1;
							prev_q     <= rd_q;
							prev_end_q <= 11'(rb) + rl;
							pos_q      <= pos_q + CW'(1);
							state_q    <= ffha_pkg::S_SCAN;
						end else begin
							// pos_q is the first hole above start.
							logic jp, jn;
							jp = has_prev_q && prev_end_q == {1'b0, start_q};
							jn = in_scan_range && {2'b0, rb} == free_end;
							if ((has_prev_q && prev_end_q > {1'b0, start_q}) ||
							    (in_scan_range && {2'b0, rb} < free_end)) begin
								st_q    <= ffha_pkg::ST_NOFIT;
								state_q <= ffha_pkg::S_DONE;
							end else if (jp && jn) begin
								st_q    <= ffha_pkg::ST_OK;
								used_q  <= used_q - size_q;
								carry_q <= {prev_q[20:11], prev_q[10:0] + size_q + rl};
								j_q     <= pos_q - CW'(1);
								merge_both_q <= 1'b1;
								state_q <= ffha_pkg::S_WRITE;
							end else if (jp) begin
								st_q    <= ffha_pkg::ST_OK;
								used_q  <= used_q - size_q;
								carry_q <= {prev_q[20:11], prev_q[10:0] + size_q};
								j_q     <= pos_q - CW'(1);
								state_q <= ffha_pkg::S_WRITE;
							end else if (jn) begin
								st_q    <= ffha_pkg::ST_OK;
								used_q  <= used_q - size_q;
								carry_q <= {start_q, rl + size_q};
								j_q     <= pos_q;
								state_q <= ffha_pkg::S_WRITE;
							end else if (total_q >= CW'(MAX_HOLES)) begin
								st_q    <= ffha_pkg::ST_FULL;
								state_q <= ffha_pkg::S_DONE;
							end else begin
								// Insert: shift entries pos..total-1 up by one.
								st_q    <= ffha_pkg::ST_OK;
								used_q  <= used_q - size_q;
								carry_q <= {start_q, size_q};
								ins_q   <= 1'b1;
								j_q     <= pos_q;
								state_q <= ffha_pkg::S_NEXT;
							end
						end
					end
				end
				ffha_pkg::S_NEXT: begin
					// Insert step: read entry j before overwriting it.
					if (j_q >= total_q) begin
						total_q <= total_q + CW'(1);
						state_q <= ffha_pkg::S_WRITE;
					end else begin
						state_q <= ffha_pkg::S_SHIFT;
					end
				end
				ffha_pkg::S_SHIFT: begin
					if (ins_q) begin
						// Write carry to j and carry the old value of j upward.
						carry_q <= rd_q;
						j_q     <= j_q + CW'(1);
						state_q <= ffha_pkg::S_NEXT;
					end else begin
						// Drop: read entry j, then write it to j-1.
						if (j_q > total_q)
							state_q <= ffha_pkg::S_DONE;
						else
							state_q <= ffha_pkg::S_DROP;
					end
				end
				ffha_pkg::S_DROP: begin
					// Entry j has been copied down to j-1.
					j_q     <= j_q + CW'(1);
					state_q <= ffha_pkg::S_SHIFT;
				end
				ffha_pkg::S_WRITE: begin
					if (merge_both_q) begin
						merge_both_q <= 1'b0;
						ins_q        <= 1'b0;
						j_q          <= pos_q + CW'(1);
						total_q      <= total_q - CW'(1);
						state_q      <= ffha_pkg::S_SHIFT;
					end else begin
						state_q <= ffha_pkg::S_DONE;
					end
				end
				ffha_pkg::S_DONE: begin
					if (!out_busy_q || m_axis_tready) begin
						out_q <= {2'b0, 7'(total_q), used_q,
						          (st_q == ffha_pkg::ST_OK ? grant_q : 10'd0), st_q};
						state_q <= ffha_pkg::S_IDLE;
					end
				end
				default: state_q <= ffha_pkg::S_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ffha_pkg::S_DONE && out_busy_q && !m_axis_tready) |=> out_busy_q)
		else $error("result lost under stall");
	a_table_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CW'(MAX_HOLES))
		else $error("hole count beyond table");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ffha_pkg::S_IDLE) |-> !s_axis_tready)
		else $error("request accepted while busy");
	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("result changed under stall");
`endif
endmodule
`default_nettype wire

[bench/testbench.sv]
// Self-checking testbench for the first-fit hole allocator core.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
	localparam int MEM_UNITS = 1024;
	localparam int HOLE_SLOTS = 64;
	localparam int DRAIN_CYCLES = 400;
	localparam int HOLD_CYCLES = 3000;

	typedef struct packed {
		ffha_pkg::req_t kind;
		logic [10:0]    size;
		logic [9:0]     start;
	} request_t;

	typedef struct packed {
		ffha_pkg::status_t status;
		logic [9:0]        grant;
		logic [10:0]       used;
		logic [6:0]        holes;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;

	first_fit_hole_allocator_core DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #1 clk = ~clk;

	// Shadow of the hole table and usage counter.
	int hole_base[HOLE_SLOTS];
	int hole_len[HOLE_SLOTS];
	int hole_count;
	int units_used;

	// Allocated blocks the stimulus knows about, used to build legal frees.
	int owned_base[$];
	int owned_len[$];

	request_t pending_requests[$];
	outcome_t expected_outcomes[$];
	int mismatch_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_go = 1'b0;
	bit hold_off = 1'b0;

	function automatic void remove_hole(int k);
		for (int j = k; j + 1 < hole_count; j++) begin
			hole_base[j] = hole_base[j + 1];
			hole_len[j] = hole_len[j + 1];
		end
		hole_count--;
	endfunction

	// Apply one request to the shadow table and return the expected outcome.
	function automatic outcome_t allocate_or_release(request_t r);
		outcome_t o;
		int sz, st, en, pos;
		bit prev_ok, next_ok, jp, jn;
		o.status = ffha_pkg::ST_NOFIT;
		o.grant = '0;
		sz = r.size;
		st = r.start;
		if (r.kind == ffha_pkg::REQ_ALLOC) begin
			if (sz != 0) begin
				for (int i = 0; i < hole_count; i++) begin
					if (hole_len[i] >= sz) begin
						o.status = ffha_pkg::ST_OK;
						o.grant = hole_base[i][9:0];
						units_used += sz;
						if (hole_len[i] == sz) remove_hole(i);
						else begin
							hole_base[i] += sz;
							hole_len[i] -= sz;
						end
						break;
					end
				end
			end
		end else begin
			en = st + sz;
			if (sz != 0 && en <= MEM_UNITS) begin
				pos = 0;
				while (pos < hole_count && hole_base[pos] <= st) pos++;
				prev_ok = pos > 0;
				next_ok = pos < hole_count;
				if (!(prev_ok && hole_base[pos-1] + hole_len[pos-1] > st) &&
				    !(next_ok && hole_base[pos] < en)) begin
					jp = prev_ok && hole_base[pos-1] + hole_len[pos-1] == st;
					jn = next_ok && hole_base[pos] == en;
					o.status = ffha_pkg::ST_OK;
					if (jp && jn) begin
						hole_len[pos-1] += sz + hole_len[pos];
						remove_hole(pos);
					end else if (jp) begin
						hole_len[pos-1] += sz;
					end else if (jn) begin
						hole_base[pos] = st;
						hole_len[pos] += sz;
					end else if (hole_count >= HOLE_SLOTS) begin
						o.status = ffha_pkg::ST_FULL;
					end else begin
						for (int j = hole_count; j > pos; j--) begin
							hole_base[j] = hole_base[j-1];
							hole_len[j] = hole_len[j-1];
						end
						hole_base[pos] = st;
						hole_len[pos] = sz;
						hole_count++;
					end
					if (o.status == ffha_pkg::ST_OK) units_used -= sz;
				end
			end
		end
		o.used = units_used[10:0];
		o.holes = hole_count[6:0];
		return o;
	endfunction

	// Shadow of the stimulus view, updated when items are queued (order is kept).
	int plan_base[HOLE_SLOTS];
	int plan_len[HOLE_SLOTS];
	int plan_count;

	function automatic void push_item(ffha_pkg::req_t k, int sz, int st);
		request_t r;
		outcome_t o;
		int keep_base[HOLE_SLOTS];
		int keep_len[HOLE_SLOTS];
		int keep_count, keep_used;
		r.kind = k;
		r.size = sz[10:0];
		r.start = st[9:0];
		pending_requests.push_back(r);
		// Predict on the planning copy and leave the checking shadow as it was.
		keep_base = hole_base; keep_len = hole_len;
		keep_count = hole_count; keep_used = units_used;
		hole_base = plan_base; hole_len = plan_len; hole_count = plan_count;
		o = allocate_or_release(r);
		plan_base = hole_base; plan_len = hole_len; plan_count = hole_count;
		hole_base = keep_base; hole_len = keep_len;
		hole_count = keep_count; units_used = keep_used;
		if (o.status == ffha_pkg::ST_OK && k == ffha_pkg::REQ_ALLOC) begin
			owned_base.push_back(o.grant);
			owned_len.push_back(sz);
		end
	endfunction

	// Free part of an owned block: the whole block, or a slice of it.
	task automatic push_owned_free();
		int idx, b, l, off, n;
		idx = $urandom_range(owned_base.size() - 1);
		b = owned_base[idx];
		l = owned_len[idx];
		owned_base.delete(idx);
		owned_len.delete(idx);
		if (l > 1 && $urandom_range(3) == 0) begin
			off = $urandom_range(l - 1);
			n = $urandom_range(l - off, 1);
			push_item(ffha_pkg::REQ_FREE, n, b + off);
			if (off > 0) begin
				owned_base.push_back(b);
				owned_len.push_back(off);
			end
			if (off + n < l) begin
				owned_base.push_back(b + off + n);
				owned_len.push_back(l - off - n);
			end
		end else
			push_item(ffha_pkg::REQ_FREE, l, b);
	endtask

	task automatic push_random_item();
		int sel;
		sel = $urandom_range(99);
		if (sel < 45) begin
			if ($urandom_range(9) == 0)
				push_item(ffha_pkg::REQ_ALLOC, $urandom_range(2047), 0);
			else
				push_item(ffha_pkg::REQ_ALLOC, $urandom_range(48, 1), $urandom_range(1023));
		end else if (sel < 90 && owned_base.size() > 0) begin
			push_owned_free();
		end else begin
			// Noise: arbitrary free, usually rejected.
			push_item(ffha_pkg::REQ_FREE, $urandom_range(2047), $urandom_range(1023));
		end
	endtask

	task automatic wait_drained();
		while (pending_requests.size() > 0 || expected_outcomes.size() > 0)
			@(posedge clk);
	endtask

	// Driver: presents queued requests, idling at random.
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			expected_outcomes.push_back(allocate_or_release(pending_requests.pop_front()));
		end
		if ((!s_axis_tvalid || s_axis_tready)) begin
			if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				request_t nxt;
				nxt = pending_requests[0];
				s_axis_tvalid <= 1'b1;
				s_axis_tuser <= nxt.kind;
				s_axis_tdata <= {3'b000, nxt.start, nxt.size};
			end else
				s_axis_tvalid <= 1'b0;
		end
	end

	// Monitor: checks each result against the oldest expectation.
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			outcome_t got, exp_o;
			got.status = ffha_pkg::status_t'(m_axis_tdata[1:0]);
			got.grant = m_axis_tdata[11:2];
			got.used = m_axis_tdata[22:12];
			got.holes = m_axis_tdata[29:23];
			if (expected_outcomes.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result transaction: %h", m_axis_tdata);
			end else begin
				exp_o = expected_outcomes.pop_front();
				if (got !== exp_o) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"mismatch: expected st=%0d addr=%0d used=%0d holes=%0d,",
							" got st=%0d addr=%0d used=%0d holes=%0d"},
							exp_o.status, exp_o.grant, exp_o.used, exp_o.holes,
							got.status, got.grant, got.used, got.holes);
				end
			end
		end
		m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
	end

	// Long receiver hold-off, counted in cycles once requested.
	initial begin
		wait (hold_go);
		hold_off = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off = 1'b0;
	end

	initial begin
		int frees;
		plan_base[0] = 0; plan_len[0] = MEM_UNITS; plan_count = 1;
		hole_base[0] = 0; hole_len[0] = MEM_UNITS; hole_count = 1; units_used = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: rejected and boundary requests, then fill and empty memory.
		push_item(ffha_pkg::REQ_ALLOC, 0, 0);
		push_item(ffha_pkg::REQ_FREE, 0, 5);
		push_item(ffha_pkg::REQ_ALLOC, 2047, 1023);
		push_item(ffha_pkg::REQ_FREE, 1, 1023);
		push_item(ffha_pkg::REQ_ALLOC, 1024, 0);
		push_item(ffha_pkg::REQ_ALLOC, 1, 0);
		push_item(ffha_pkg::REQ_FREE, 2, 1023);
		push_item(ffha_pkg::REQ_FREE, 1024, 0);
		push_item(ffha_pkg::REQ_ALLOC, 1, 0);
		push_item(ffha_pkg::REQ_ALLOC, 1022, 0);
		push_item(ffha_pkg::REQ_ALLOC, 1, 0);
		push_item(ffha_pkg::REQ_FREE, 1, 1023);
		push_item(ffha_pkg::REQ_FREE, 1, 0);
		push_item(ffha_pkg::REQ_FREE, 1022, 1);
		push_item(ffha_pkg::REQ_FREE, 1, 1023);
		owned_base.delete(); owned_len.delete();
		wait_drained();

		// Checkerboard: 128 one-unit blocks, free every other one to fill the table.
		for (int i = 0; i < 128; i++) push_item(ffha_pkg::REQ_ALLOC, 1, 0);
		for (int i = 0; i < 128; i += 2) push_item(ffha_pkg::REQ_FREE, 1, i);
		// Table now full after the refused isolated free at 126; merging frees still work.
		push_item(ffha_pkg::REQ_FREE, 1, 1);
		push_item(ffha_pkg::REQ_FREE, 1, 127);
		for (int i = 1; i < 126; i += 2) push_item(ffha_pkg::REQ_FREE, 1, i);
		owned_base.delete(); owned_len.delete();
		wait_drained();

		// Long receiver hold-off while the sender keeps offering.
		hold_go = 1'b1;
		for (int i = 0; i < 20; i++) push_random_item();
		wait (hold_off);
		wait (!hold_off);
		wait_drained();

		// Random phases with varied idling.
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
				3: begin send_idle_pct = 37; recv_stall_pct = 37; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			for (int i = 0; i < 130; i++) begin
				push_random_item();
				while (pending_requests.size() > 8) @(posedge clk);
			end
			wait_drained();
		end

		// Release everything still held to end on merged memory.
		frees = owned_base.size();
		for (int i = 0; i < frees; i++) push_owned_free();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_outcomes.size() == 0)
			$display("first_fit_hole_allocator_core regression: pass");
		else
			$display("first_fit_hole_allocator_core regression: fail");
		$finish;
	end

	initial begin
		#4000000;
		$display("first_fit_hole_allocator_core regression: fail");
		$finish;
	end
endmodule
`default_nettype wire
